// ===== sv/playfair_digraph_cipher_defines.svh =====
// Assertion macros for the Playfair digraph cipher.
// Included by the top level only; needs clk and arst_n in scope.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`ifndef SYNTH
// A condition that must hold at every clock edge out of reset.
`define PFC_ASSERT(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// A condition that must hold in the cycle after the trigger.
`define PFC_ASSERT_NEXT(name, trig, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);
`else
`define PFC_ASSERT(name, cond, msg)
`define PFC_ASSERT_NEXT(name, trig, cond, msg)
`endif
`endif

// ===== sv/pfc_pkg.sv =====
// Shared types, codes and helper functions for the Playfair digraph cipher.
// No dependencies; used by every module of the block except pfc_ram.
`timescale 1ns / 1ps

package pfc_pkg;

	localparam logic [1:0] REQ_KEY = 2'd0;
	localparam logic [1:0] REQ_ENC = 2'd1;
	localparam logic [1:0] REQ_DEC = 2'd2;

	localparam logic [4:0] LETTER_I = 5'd8;
	localparam logic [4:0] LETTER_J = 5'd9;
	localparam logic [4:0] LETTER_Z = 5'd25;
	localparam logic [4:0] TABLE_SIZE = 5'd25;
	localparam logic [2:0] SIDE_MAX = 3'd4;

	localparam int ALPHABET = 26;
	localparam int TABLE_DEPTH = 25;
	localparam int POS_WIDTH = 6;

	typedef struct packed {
		logic [1:0] req_type;
		logic [4:0] first_letter;
		logic [4:0] second_letter;
		logic       key_last;
	} in_t;

	typedef struct packed {
		logic [4:0] out_first;
		logic [4:0] out_second;
		logic       status;
	} out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_KEY,
		S_FILL,
		S_POS,
		S_TAB,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load_in;
		logic place_key;
		logic place_fill;
		logic set_ready;
		logic pos_rd;
		logic tab_rd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic ready;
		logic fill_end;
	} sts_t;

	function automatic logic [4:0] sat_letter(input logic [4:0] v);
		return (v > LETTER_Z) ? LETTER_Z : v;
	endfunction

	function automatic logic [4:0] j_to_i(input logic [4:0] v);
		return (v == LETTER_J) ? LETTER_I : v;
	endfunction

	// Cyclic step of a row or column index: forward to encrypt, back to decrypt.
	function automatic logic [2:0] step_idx(input logic [2:0] x, input logic fwd);
		logic [2:0] r;
		if (fwd) begin
			r = (x == SIDE_MAX) ? 3'd0 : x + 3'd1;
		end else begin
			r = (x == 3'd0) ? SIDE_MAX : x - 3'd1;
		end
		return r;
	endfunction

	function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
		return {r, 2'b00} + {2'b00, r} + {2'b00, c};
	endfunction

endpackage

// ===== sv/playfair_digraph_cipher.sv =====
// Top level of the Playfair digraph cipher.
// Depends on pfc_pkg, pfc_ctrl, pfc_datapath and the assertion macro header.
`timescale 1ns / 1ps
`include "playfair_digraph_cipher_defines.svh"

// Playfair cipher on letter codes a=0 to z=25, one request at a time. Send key
// letters with req_type 0 and mark the final one with key_last; the remaining
// letters are then filled in and the table becomes usable. A key letter sent on
// a finished table starts a new key. Encrypt (1) and decrypt (2) requests return
// one transformed digraph, or status 1 if no table is ready yet. Every request
// returns exactly one response. Before its response is loaded, a plain key letter
// passes the key placement state, the final key letter also the fill walk over all
// 26 letters, one letter per cycle; a digraph two registered memory reads in series
// (letter position, then table entry); a rejected or unused request goes straight to
// the response state. The request side is ready again once the response is loaded,
// even while that response still waits to be taken.
module playfair_digraph_cipher import pfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  in_t  req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output out_t rsp
);

	cmd_t cmd;
	sts_t sts;

	pfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pfc_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

	`PFC_ASSERT(a_tab_needs_ready, !cmd.tab_rd || sts.ready, "table read without a ready table")
	`PFC_ASSERT(a_one_command, $onehot0({cmd.place_key, cmd.place_fill, cmd.pos_rd, cmd.tab_rd, cmd.out_load}), "conflicting datapath commands")
	`PFC_ASSERT_NEXT(a_busy_after_transfer, req_valid && req_ready, !req_ready, "request taken while busy")
	`PFC_ASSERT_NEXT(a_load_shows, cmd.out_load, rsp_valid, "loaded response not presented")

endmodule

// ===== sv/pfc_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module pfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ===== sv/pfc_ctrl.sv =====
// Controller state machine for the Playfair digraph cipher.
// Depends on pfc_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module pfc_ctrl import pfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_type,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t state_q, state_next;
	logic   rsp_valid_q;
	logic   accept;
	logic   out_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_KEY) begin
						state_next = S_KEY;
					end else if ((req_type == REQ_ENC || req_type == REQ_DEC) && sts.ready) begin
						state_next = S_POS;
					end else begin
						state_next = S_RESP;
					end
				end
			end
			S_KEY: begin
				state_next = sts.last ? S_FILL : S_RESP;
			end
			S_FILL: begin
				if (sts.fill_end) begin
					state_next = S_RESP;
				end
			end
			S_POS: begin
				state_next = S_TAB;
			end
			S_TAB: begin
				state_next = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = accept;
			end
			S_KEY: begin
				cmd.place_key = 1'b1;
			end
			S_FILL: begin
				cmd.place_fill = 1'b1;
				cmd.set_ready  = sts.fill_end;
			end
			S_POS: begin
				cmd.pos_rd = 1'b1;
			end
			S_TAB: begin
				cmd.tab_rd = 1'b1;
			end
			S_RESP: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/pfc_datapath.sv =====
// Datapath for the Playfair digraph cipher: key table build and digraph lookup.
// Depends on pfc_pkg and pfc_ram; controlled by pfc_ctrl through cmd_t.
`timescale 1ns / 1ps

module pfc_datapath import pfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  in_t  req,
	input  cmd_t cmd,
	output sts_t sts,
	output out_t rsp
);

	logic [1:0]          req_type_q;
	logic [4:0]          a_q;
	logic [4:0]          b_q;
	logic                last_q;
	logic [ALPHABET-1:0] seen_q;
	logic [4:0]          fill_q;
	logic [2:0]          frow_q;
	logic [2:0]          fcol_q;
	logic                ready_q;
	logic [4:0]          k_q;
	out_t                rsp_q;

	logic                placing;
	logic                restart;
	logic [4:0]          ch;
	logic [ALPHABET-1:0] eff_seen;
	logic [4:0]          eff_fill;
	logic [2:0]          eff_row;
	logic [2:0]          eff_col;
	logic                do_place;
	logic [ALPHABET-1:0] seen_next;
	logic [4:0]          fill_next;
	logic [2:0]          row_next;
	logic [2:0]          col_next;

	logic [POS_WIDTH-1:0] pos_a;
	logic [POS_WIDTH-1:0] pos_b;
	logic [2:0]           ra, ca, rb, cb;
	logic                 fwd;
	logic [4:0]           tab_addr_a;
	logic [4:0]           tab_addr_b;
	logic [4:0]           tab_a;
	logic [4:0]           tab_b;
	logic                 digraph;
	out_t                 rsp_next;

	// A key letter arriving on a finished table starts a new key from scratch.
	assign placing  = cmd.place_key || cmd.place_fill;
	assign restart  = cmd.place_key && ready_q;
	assign ch       = cmd.place_key ? a_q : k_q;
	assign eff_seen = restart ? '0 : seen_q;
	assign eff_fill = restart ? 5'd0 : fill_q;
	assign eff_row  = restart ? 3'd0 : frow_q;
	assign eff_col  = restart ? 3'd0 : fcol_q;
	assign do_place = placing && (ch != LETTER_J) && !eff_seen[ch] && (eff_fill < TABLE_SIZE);

	always_comb begin
		seen_next = eff_seen;
		fill_next = eff_fill;
		row_next  = eff_row;
		col_next  = eff_col;
		if (do_place) begin
			seen_next[ch] = 1'b1;
			fill_next     = eff_fill + 5'd1;
			if (eff_col == SIDE_MAX) begin
				col_next = 3'd0;
				row_next = eff_row + 3'd1;
			end else begin
				col_next = eff_col + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_type_q <= req.req_type;
			a_q        <= sat_letter(req.first_letter);
			b_q        <= sat_letter(req.second_letter);
			last_q     <= req.key_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			fill_q  <= '0;
			frow_q  <= '0;
			fcol_q  <= '0;
			ready_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (placing) begin
				seen_q <= seen_next;
				fill_q <= fill_next;
				frow_q <= row_next;
				fcol_q <= col_next;
			end
			if (restart) begin
				ready_q <= 1'b0;
			end else if (cmd.set_ready) begin
				ready_q <= 1'b1;
			end
			if (cmd.place_key) begin
				k_q <= '0;
			end else if (cmd.place_fill) begin
				k_q <= k_q + 5'd1;
			end
		end
	end

	pfc_ram #(
		.WIDTH(POS_WIDTH),
		.DEPTH(ALPHABET)
	) u_pos_ram (
		.clk     (clk),
		.we      (do_place),
		.waddr   (ch),
		.wdata   ({eff_row, eff_col}),
		.re      (cmd.pos_rd),
		.raddr_a (j_to_i(a_q)),
		.raddr_b (j_to_i(b_q)),
		.rdata_a (pos_a),
		.rdata_b (pos_b)
	);

	assign ra  = pos_a[5:3];
	assign ca  = pos_a[2:0];
	assign rb  = pos_b[5:3];
	assign cb  = pos_b[2:0];
	assign fwd = (req_type_q == REQ_ENC);

	always_comb begin
		if (ra == rb) begin
			tab_addr_a = cell_addr(ra, step_idx(ca, fwd));
			tab_addr_b = cell_addr(rb, step_idx(cb, fwd));
		end else if (ca == cb) begin
			tab_addr_a = cell_addr(step_idx(ra, fwd), ca);
			tab_addr_b = cell_addr(step_idx(rb, fwd), cb);
		end else begin
			tab_addr_a = cell_addr(ra, cb);
			tab_addr_b = cell_addr(rb, ca);
		end
	end

	pfc_ram #(
		.WIDTH(5),
		.DEPTH(TABLE_DEPTH)
	) u_tab_ram (
		.clk     (clk),
		.we      (do_place),
		.waddr   (eff_fill),
		.wdata   (ch),
		.re      (cmd.tab_rd),
		.raddr_a (tab_addr_a),
		.raddr_b (tab_addr_b),
		.rdata_a (tab_a),
		.rdata_b (tab_b)
	);

	assign digraph = (req_type_q == REQ_ENC) || (req_type_q == REQ_DEC);

	always_comb begin
		rsp_next = '0;
		if (digraph && ready_q) begin
			rsp_next.out_first  = tab_a;
			rsp_next.out_second = tab_b;
		end else if (digraph) begin
			rsp_next.status = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp          = rsp_q;
	assign sts.last     = last_q;
	assign sts.ready    = ready_q;
	assign sts.fill_end = (k_q == LETTER_Z);

endmodule
